// ===== hw/rtl/pshd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the pin sample hex dump monitor.
package pshd_pkg;

	localparam int BYTE_W      = 8;
	localparam int CHAR_W      = 7;
	localparam int COUNT_W     = 9;
	localparam int BITPOS_W    = 3;
	localparam int CMD_DEPTH   = 4;

	localparam logic [BYTE_W-1:0]   ROW_LENGTH_RST  = 8'd32;
	localparam logic [BYTE_W-1:0]   MAX_REPEATS_RST = 8'd8;
	localparam logic [BITPOS_W-1:0] BITPOS_FIRST    = 3'd7;

	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A_BIAS  = 7'h37;  // 'A' - 10
	localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 7'h0a;
	localparam logic [CHAR_W-1:0] CHAR_DOT     = 7'h2e;

	typedef enum logic {
		REG_ROW_LENGTH  = 1'b0,
		REG_MAX_REPEATS = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		CMD_HEX      = 2'd0,
		CMD_HEX_NL   = 2'd1,
		CMD_ELLIPSIS = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [BYTE_W-1:0] data;
	} cmd_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
		logic [CHAR_W-1:0] wide;
		wide = {3'b000, nib};
		if (nib < 4'd10) begin
			hex_char = CHAR_ZERO + wide;
		end else begin
			hex_char = CHAR_A_BIAS + wide;
		end
	endfunction

endpackage

// ===== hw/rtl/pshd_front.sv =====
`timescale 1ns / 1ps
// Front end: byte assembly, run tracking, row counting, command generation.
module pshd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        pin_level,
	input  logic                        wr_en,
	input  logic                        wr_index,
	input  logic [pshd_pkg::BYTE_W-1:0] wr_data,
	output logic                        cmd_push,
	output pshd_pkg::cmd_t              cmd
);

	logic [pshd_pkg::BYTE_W-1:0]   row_length_q;
	logic [pshd_pkg::BYTE_W-1:0]   max_repeats_q;
	logic [pshd_pkg::BYTE_W-1:0]   shift_byte_q;
	logic [pshd_pkg::BITPOS_W-1:0] bit_position_q;
	logic [pshd_pkg::BYTE_W-1:0]   row_left_q;
	logic [pshd_pkg::BYTE_W-1:0]   previous_byte_q;
	logic [pshd_pkg::COUNT_W-1:0]  repeat_count_q;

	logic [pshd_pkg::BYTE_W-1:0]  done_byte;
	logic                         byte_done;
	logic [pshd_pkg::COUNT_W-1:0] limit;
	logic [pshd_pkg::COUNT_W-1:0] count_next;
	logic [pshd_pkg::BYTE_W-1:0]  row_dec;
	logic                         show_hex;
	logic                         show_dots;

	assign byte_done = accept && (bit_position_q == '0);
	assign done_byte = shift_byte_q | {{(pshd_pkg::BYTE_W-1){1'b0}}, pin_level};
	assign limit     = {1'b0, max_repeats_q};
	assign row_dec   = row_left_q - 8'd1;

	always_comb begin
		if (done_byte == previous_byte_q) begin
			// count saturates one past the limit, also when the limit was lowered
			if (repeat_count_q <= limit) begin
				count_next = repeat_count_q + 9'd1;
			end else begin
				count_next = limit + 9'd1;
			end
		end else begin
			count_next = '0;
		end
	end

	assign show_hex  = count_next < limit;
	assign show_dots = count_next == limit;

	always_comb begin
		cmd_push = byte_done && (show_hex || show_dots);
		cmd.data = done_byte;
		if (show_dots) begin
			cmd.kind = pshd_pkg::CMD_ELLIPSIS;
		end else if (row_dec == '0) begin
			cmd.kind = pshd_pkg::CMD_HEX_NL;
		end else begin
			cmd.kind = pshd_pkg::CMD_HEX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q    <= pshd_pkg::ROW_LENGTH_RST;
			max_repeats_q   <= pshd_pkg::MAX_REPEATS_RST;
			shift_byte_q    <= '0;
			bit_position_q  <= pshd_pkg::BITPOS_FIRST;
			row_left_q      <= pshd_pkg::ROW_LENGTH_RST;
			previous_byte_q <= '0;
			repeat_count_q  <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					pshd_pkg::REG_ROW_LENGTH: begin
						row_length_q <= wr_data;
						row_left_q   <= wr_data;
					end
					pshd_pkg::REG_MAX_REPEATS: begin
						max_repeats_q <= wr_data;
					end
					default: begin
					end
				endcase
			end
			if (accept) begin
				if (bit_position_q != '0) begin
					shift_byte_q   <= shift_byte_q |
						(pshd_pkg::BYTE_W'(pin_level) << bit_position_q);
					bit_position_q <= bit_position_q - 3'd1;
				end else begin
					shift_byte_q    <= '0;
					bit_position_q  <= pshd_pkg::BITPOS_FIRST;
					previous_byte_q <= done_byte;
					repeat_count_q  <= count_next;
					if (show_hex) begin
						row_left_q <= (row_dec == '0) ? row_length_q : row_dec;
					end
				end
			end
		end
	end

endmodule

// ===== hw/rtl/pshd_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Short command queue between the front and back ends (depth of 2 or more).
module pshd_cmd_fifo #(
	parameter int DEPTH = pshd_pkg::CMD_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pshd_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           nonempty,
	output pshd_pkg::cmd_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	pshd_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = count_q == CNT_FULL;
	assign nonempty = count_q != '0;
	assign head     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CNT_ONE;
				2'b01:   count_q <= count_q - CNT_ONE;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/pshd_back.sv =====
`timescale 1ns / 1ps
// Back end: expands one command into its characters, one beat per cycle while pop keeps up.
module pshd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	input  pshd_pkg::cmd_t              cmd,
	output logic                        cmd_pop,
	input  logic                        pop,
	output logic                        empty,
	output logic [pshd_pkg::CHAR_W-1:0] text_char,
	output logic                        last_of_run
);

	logic [1:0]                  idx_q;
	logic                        out_valid_q;
	logic [pshd_pkg::CHAR_W-1:0] char_q;
	logic                        last_q;

	logic                        emit;
	logic                        is_last;
	logic [pshd_pkg::CHAR_W-1:0] char_next;

	assign emit    = cmd_valid && (!out_valid_q || pop);
	assign is_last = (cmd.kind == pshd_pkg::CMD_HEX) ? (idx_q == 2'd2) : (idx_q == 2'd3);
	assign cmd_pop = emit && is_last;

	always_comb begin
		if (cmd.kind == pshd_pkg::CMD_ELLIPSIS) begin
			char_next = (idx_q == 2'd3) ? pshd_pkg::CHAR_SPACE : pshd_pkg::CHAR_DOT;
		end else begin
			case (idx_q)
				2'd0:    char_next = pshd_pkg::hex_char(cmd.data[7:4]);
				2'd1:    char_next = pshd_pkg::hex_char(cmd.data[3:0]);
				2'd2:    char_next = pshd_pkg::CHAR_SPACE;
				default: char_next = pshd_pkg::CHAR_NEWLINE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= char_next;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty       = !out_valid_q;
	assign text_char   = char_q;
	assign last_of_run = last_q;

endmodule

// ===== hw/rtl/pin_sample_hex_dump_monitor_core.sv =====
`timescale 1ns / 1ps
// Top level of the pin sample hex dump monitor.
//
// One pin sample is taken per cycle (push while full is low). Every eighth
// sample completes a byte, first sample in bit 7, and yields zero to four
// characters: two hex digits and a space, plus a newline at row end, or
// "... " once a run of identical bytes reaches max_repeats; the rest of the
// run is silent. The front end turns each byte that yields characters into
// one command in a CMD_DEPTH-entry queue (default 4, at least 2); the back
// end drains it at one character per cycle while pop stays high, into an
// output register, so full only rises when the result side stalls for long.
// Each character is one beat on the result side; last_of_run marks the
// final character of a byte. Write row_length and max_repeats only while
// idle; writing row_length also restarts the current row.
module pin_sample_hex_dump_monitor_core #(
	parameter int CMD_DEPTH = pshd_pkg::CMD_DEPTH
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        pin_level,
	output logic                        empty,
	input  logic                        pop,
	output logic [pshd_pkg::CHAR_W-1:0] text_char,
	output logic                        last_of_run,
	input  logic                        wr_en,
	input  logic                        wr_index,
	input  logic [pshd_pkg::BYTE_W-1:0] wr_data
);

	logic           accept;
	logic           cmd_push;
	pshd_pkg::cmd_t cmd_in;
	logic           cmd_pop;
	logic           cmd_valid;
	pshd_pkg::cmd_t cmd_head;

	assign accept = push && !full;

	pshd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.pin_level (pin_level),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	pshd_cmd_fifo #(
		.DEPTH (CMD_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (cmd_push),
		.push_cmd (cmd_in),
		.pop      (cmd_pop),
		.full     (full),
		.nonempty (cmd_valid),
		.head     (cmd_head)
	);

	pshd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd_head),
		.cmd_pop     (cmd_pop),
		.pop         (pop),
		.empty       (empty),
		.text_char   (text_char),
		.last_of_run (last_of_run)
	);

endmodule

// ===== verif/pin_sample_hex_dump_monitor_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the pin sample hex dump monitor core.
module pin_sample_hex_dump_monitor_core_tb;

	localparam logic [pshd_pkg::CHAR_W-1:0] ASCII_0     = 7'h30;
	localparam logic [pshd_pkg::CHAR_W-1:0] ASCII_A     = 7'h41;
	localparam logic [pshd_pkg::CHAR_W-1:0] ASCII_SPACE = 7'h20;
	localparam logic [pshd_pkg::CHAR_W-1:0] ASCII_NL    = 7'h0a;
	localparam logic [pshd_pkg::CHAR_W-1:0] ASCII_DOT   = 7'h2e;
	localparam int IDLE_PCT      = 36;
	localparam int LONG_STALL    = 150;
	localparam int DRAIN_CYCLES  = 12;
	localparam int MAX_REPORTS   = 10;

	typedef struct packed {
		logic [pshd_pkg::CHAR_W-1:0] ch;
		logic                        last;
	} dump_char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pin_level = 1'b0;
	logic pop = 1'b0;
	logic wr_en = 1'b0;
	logic wr_index = 1'b0;
	logic [pshd_pkg::BYTE_W-1:0] wr_data = '0;
	logic full;
	logic empty;
	logic [pshd_pkg::CHAR_W-1:0] text_char;
	logic last_of_run;

	pin_sample_hex_dump_monitor_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.pin_level(pin_level),
		.empty(empty),
		.pop(pop),
		.text_char(text_char),
		.last_of_run(last_of_run),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #1 clk = ~clk;

	// Predictor state, mirrors the block after reset
	logic [pshd_pkg::BYTE_W-1:0]   row_len_q   = 8'd32;
	logic [pshd_pkg::BYTE_W-1:0]   max_rep_q   = 8'd8;
	logic [pshd_pkg::BYTE_W-1:0]   shift_q     = '0;
	logic [pshd_pkg::BITPOS_W-1:0] bitpos_q    = 3'd7;
	logic [pshd_pkg::BYTE_W-1:0]   row_left_q  = 8'd32;
	logic [pshd_pkg::BYTE_W-1:0]   prev_byte_q = '0;
	logic [pshd_pkg::COUNT_W-1:0]  run_q       = '0;

	logic       pending_levels[$];
	dump_char_t expected_text[$];

	logic no_gaps = 1'b0;
	logic [pshd_pkg::BYTE_W-1:0] last_gen_byte = '0;
	int samples_in = 0;
	int bytes_done = 0;
	int beats_out = 0;
	int ellipses = 0;
	int newlines = 0;
	int mismatches = 0;
	int stall_left = 0;
	bit long_stall_done = 0;

	function automatic logic [pshd_pkg::CHAR_W-1:0] nibble_ascii(input logic [3:0] nib);
		if (nib < 4'd10)
			return ASCII_0 + pshd_pkg::CHAR_W'(nib);
		return ASCII_A + pshd_pkg::CHAR_W'(nib) - pshd_pkg::CHAR_W'(10);
	endfunction

	task automatic predict_dump(input logic lvl);
		logic [pshd_pkg::BYTE_W-1:0]  done;
		logic [pshd_pkg::COUNT_W-1:0] lim;
		logic [pshd_pkg::CHAR_W-1:0]  chars[$];
		shift_q = shift_q | (pshd_pkg::BYTE_W'(lvl) << bitpos_q);
		if (bitpos_q != 3'd0) begin
			bitpos_q = bitpos_q - 3'd1;
			return;
		end
		bitpos_q = 3'd7;
		done = shift_q;
		lim = pshd_pkg::COUNT_W'(max_rep_q);
		bytes_done++;
		if (done == prev_byte_q) begin
			if (run_q <= lim)
				run_q = run_q + 9'd1;
			else
				run_q = lim + 9'd1;
		end else begin
			run_q = '0;
		end
		if (run_q < lim) begin
			chars.push_back(nibble_ascii(done[7:4]));
			chars.push_back(nibble_ascii(done[3:0]));
			chars.push_back(ASCII_SPACE);
			row_left_q = row_left_q - 8'd1;
			if (row_left_q == 8'd0) begin
				chars.push_back(ASCII_NL);
				row_left_q = row_len_q;
				newlines++;
			end
		end else if (run_q == lim) begin
			repeat (3) chars.push_back(ASCII_DOT);
			chars.push_back(ASCII_SPACE);
			ellipses++;
		end
		foreach (chars[i])
			expected_text.push_back('{ch: chars[i], last: (i == chars.size() - 1)});
		prev_byte_q = done;
		shift_q = '0;
	endtask

	// Sample driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				predict_dump(pin_level);
				samples_in++;
			end
			if (!push || !full) begin
				if (pending_levels.size() > 0 &&
					(no_gaps || $urandom_range(99) >= IDLE_PCT)) begin
					push <= 1'b1;
					pin_level <= pending_levels.pop_front();
				end else begin
					push <= 1'b0;
					pin_level <= 1'($urandom_range(1));
				end
			end
		end
	end

	task automatic note_mismatch(input string what, input int exp_v, input int act_v);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: mismatch on %s, expected 0x%0h, got 0x%0h", $realtime, what,
				exp_v, act_v);
	endtask

	// Text monitor
	always @(posedge clk) begin
		dump_char_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				beats_out++;
				if (expected_text.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected beat, char 0x%0h last %0b", $realtime,
							text_char, last_of_run);
				end else begin
					want = expected_text.pop_front();
					if (text_char !== want.ch)
						note_mismatch("text_char", want.ch, text_char);
					if (last_of_run !== want.last)
						note_mismatch("last_of_run", want.last, last_of_run);
				end
			end
			// one long hold-off while a big batch is queued, so the input backs up
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (!long_stall_done && pending_levels.size() > 100) begin
				long_stall_done = 1;
				stall_left = LONG_STALL;
				pop <= 1'b0;
			end else begin
				pop <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic write_reg(input pshd_pkg::reg_index_t idx,
		input logic [pshd_pkg::BYTE_W-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == pshd_pkg::REG_ROW_LENGTH) begin
			row_len_q = val;
			row_left_q = val;
		end else begin
			max_rep_q = val;
		end
	endtask

	task automatic set_config(input logic [pshd_pkg::BYTE_W-1:0] row,
		input logic [pshd_pkg::BYTE_W-1:0] reps);
		write_reg(pshd_pkg::REG_ROW_LENGTH, row);
		write_reg(pshd_pkg::REG_MAX_REPEATS, reps);
	endtask

	task automatic queue_byte(input logic [pshd_pkg::BYTE_W-1:0] b);
		for (int i = pshd_pkg::BYTE_W - 1; i >= 0; i--)
			pending_levels.push_back(b[i]);
	endtask

	// Bytes with frequent repeats so runs build up; a few stray samples shift alignment
	task automatic queue_random_bytes(input int n);
		int pick;
		for (int k = 0; k < n; k++) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				// repeat previous byte
			end else if (pick < 60) begin
				case ($urandom_range(3))
					0: last_gen_byte = 8'h00;
					1: last_gen_byte = 8'hff;
					2: last_gen_byte = 8'h55;
					default: last_gen_byte = 8'haa;
				endcase
			end else begin
				last_gen_byte = 8'($urandom);
			end
			queue_byte(last_gen_byte);
			if ($urandom_range(99) < 5)
				repeat ($urandom_range(1, 3)) pending_levels.push_back(1'($urandom_range(1)));
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_levels.size() != 0 || push || expected_text.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// zero first byte repeats the reset value; short row forces a newline
		set_config(8'd2, 8'd1);
		queue_byte(8'h00);
		queue_byte(8'hff);
		queue_byte(8'ha5);
		wait_drained();

		set_config(8'd1, 8'd1);
		queue_random_bytes(5);
		wait_drained();

		// zero limit: ellipsis on every new run
		write_reg(pshd_pkg::REG_MAX_REPEATS, 8'd0);
		queue_random_bytes(5);
		wait_drained();

		// limit lowered in the middle of a run
		set_config(8'd4, 8'd8);
		repeat (6) queue_byte(8'h3c);
		wait_drained();
		write_reg(pshd_pkg::REG_MAX_REPEATS, 8'd2);
		repeat (3) queue_byte(8'h3c);
		queue_byte(8'hc3);
		wait_drained();

		no_gaps = 1'b1;
		set_config(8'd0, 8'd255);
		queue_random_bytes(6);
		wait_drained();
		set_config(8'd255, 8'd3);
		queue_random_bytes(5);
		wait_drained();
		no_gaps = 1'b0;

		// big batch; the monitor holds off here and the block backs up
		set_config(8'($urandom_range(2, 12)), 8'($urandom_range(1, 6)));
		queue_random_bytes(17);
		wait_drained();

		set_config(8'd32, 8'd8);
		queue_random_bytes(4);
		wait_drained();
		set_config(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
		queue_random_bytes(4);
		wait_drained();

		if (expected_text.size() != 0)
			mismatches++;
		$display("Covered %0d samples, %0d bytes, %0d text beats (%0d ellipses, %0d newlines)",
			samples_in, bytes_done, beats_out, ellipses, newlines);
		$display("Settings included row lengths 0/1/255 and repeat limits 0/1/255, %0d errors",
			mismatches);
		if (mismatches == 0) begin
			$display("pin_sample_hex_dump_monitor_core_tb: PASS");
		end else begin
			$display("pin_sample_hex_dump_monitor_core_tb: FAIL");
		end
		$finish;
	end

	initial begin
		#200000;
		$display("pin_sample_hex_dump_monitor_core_tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/pshd_pkg.sv
hw/rtl/pshd_front.sv
hw/rtl/pshd_cmd_fifo.sv
hw/rtl/pshd_back.sv
hw/rtl/pin_sample_hex_dump_monitor_core.sv
verif/pin_sample_hex_dump_monitor_core_tb.sv
